### rtl/core/adaptive_lod_governor_macros.svh
// Assertion helpers shared by the governor RTL.
// Both expect a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ADAPTIVE_LOD_GOVERNOR_MACROS_SVH
`define ADAPTIVE_LOD_GOVERNOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ALG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ALG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/alg_pkg.sv
`timescale 1ns / 1ps

package alg_pkg;

    localparam int LVL_BITS     = 2;
    localparam int CMD_BITS     = 2;
    localparam int COLL_BITS    = 2;
    localparam int OUT_SUM_BITS = 22;
    localparam int CFG_IDX_BITS = 3;
    localparam int OUT_DEPTH    = 4;

    // Detail levels.
    localparam logic [LVL_BITS-1:0] LVL_HIGH     = 2'd0;
    localparam logic [LVL_BITS-1:0] LVL_MEDIUM   = 2'd1;
    localparam logic [LVL_BITS-1:0] LVL_LOW      = 2'd2;
    localparam logic [LVL_BITS-1:0] LVL_DISABLED = 2'd3;

    // Request kinds.
    localparam logic [CMD_BITS-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_QUERY  = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_FORCE  = 2'd2;

    // Collision modes.
    localparam logic [COLL_BITS-1:0] COLL_NONE    = 2'd0;
    localparam logic [COLL_BITS-1:0] COLL_QUERY   = 2'd1;
    localparam logic [COLL_BITS-1:0] COLL_PHYSICS = 2'd2;

    // Register indexes.
    localparam logic [CFG_IDX_BITS-1:0] REG_NEAR   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MID    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FAR    = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_TARGET = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_ADAPT  = 3'd4;

    // Reset values.
    localparam int RESET_TARGET = 16670;
    localparam int RESET_NEAR   = 1000;
    localparam int RESET_MID    = 3000;
    localparam int RESET_FAR    = 8000;

    // Distance test results for one bound, at each of the three scalings.
    typedef struct packed {
        logic le_full;
        logic le_70;
        logic le_50;
    } t_fit;

    typedef struct packed {
        logic [LVL_BITS-1:0]     object_level;
        logic                    simulate;
        logic [COLL_BITS-1:0]    collision_mode;
        logic                    notify_hits;
        logic [LVL_BITS-1:0]     global_level;
        logic                    level_changed;
        logic [OUT_SUM_BITS-1:0] window_sum;
    } t_result;

endpackage

### rtl/core/alg_ring_cell.sv
`timescale 1ns / 1ps

module alg_ring_cell #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_shift,
    input  logic [SAMPLE_BITS-1:0] i_value,
    output logic [SAMPLE_BITS-1:0] o_value
);
    import alg_pkg::*;

    logic [SAMPLE_BITS-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_value <= SAMPLE_BITS'(RESET_TARGET);
        end else if (i_shift) begin
            r_value <= i_value;
        end
    end

    assign o_value = r_value;

endmodule

### rtl/core/alg_sample_chain.sv
`timescale 1ns / 1ps

module alg_sample_chain #(
    parameter int WINDOW_LEN  = 60,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_shift,
    input  logic [SAMPLE_BITS-1:0]                     i_sample,
    output logic [SAMPLE_BITS+$clog2(WINDOW_LEN)-1:0]  o_sum
);
    import alg_pkg::*;

    localparam int SUM_BITS = SAMPLE_BITS + $clog2(WINDOW_LEN);

    logic [SAMPLE_BITS-1:0] w_tap [WINDOW_LEN+1];
    logic [SUM_BITS-1:0]    r_sum;
    logic [SUM_BITS-1:0]    n_sum;

    assign w_tap[0] = i_sample;

    // Each cell passes its sample on; the last one holds the oldest sample.
    for (genvar k = 0; k < WINDOW_LEN; k++) begin : g_cell
        alg_ring_cell #(
            .SAMPLE_BITS(SAMPLE_BITS)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_shift(i_shift),
            .i_value(w_tap[k]),
            .o_value(w_tap[k+1])
        );
    end

    assign n_sum = r_sum - SUM_BITS'(w_tap[WINDOW_LEN]) + SUM_BITS'(i_sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= SUM_BITS'(WINDOW_LEN) * SUM_BITS'(SAMPLE_BITS'(RESET_TARGET));
        end else if (i_shift) begin
            r_sum <= n_sum;
        end
    end

    assign o_sum = r_sum;

endmodule

### rtl/core/alg_out_fifo.sv
`timescale 1ns / 1ps

module alg_out_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  alg_pkg::t_result i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output alg_pkg::t_result o_data
);
    import alg_pkg::*;

    localparam int PTR_BITS = $clog2(OUT_DEPTH);
    localparam int CNT_BITS = $clog2(OUT_DEPTH + 1);

    t_result             r_mem [OUT_DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_BITS'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_BITS'(1);
            end
            r_count <= r_count + CNT_BITS'(i_push) - CNT_BITS'(i_pop);
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

### rtl/core/adaptive_lod_governor.sv
// Adaptive detail-level governor.
// Requests arrive on the input channel (i_in_valid, o_in_stall) and carry a command:
// a frame-time sample, a distance query or a forced global level. Every request
// gives exactly one result on the output channel (o_out_valid, i_out_stall).
// Registers are written on a separate valid/ready port, which is always ready;
// they should only be written while no request is outstanding.
// A request taken on the input channel is registered in the first stage; the second
// stage then writes its result into the queue, from which the receiver takes it. One
// request per cycle is sustained while o_in_stall stays low; the limit is the loop
// through the level register that steps the global level and feeds it to the next one.
// Up to four requests may be in flight or waiting; when the receiver stalls, those
// results are held in a small queue and o_in_stall rises once four are pending.
// Reset fills every sample cell with the reset target, sets the running sum to the
// window length times that target, the global level to high, and the registers to
// their documented defaults. No clearing pass is needed after reset.
`timescale 1ns / 1ps
`include "adaptive_lod_governor_macros.svh"

module adaptive_lod_governor #(
    parameter int WINDOW_LEN  = 60,
    parameter int SAMPLE_BITS = 16,
    parameter int DIST_BITS   = 20
) (
    input  logic                                               i_clk,
    input  logic                                               i_rst_n,
    // Configuration write port.
    input  logic                                               i_cfg_valid,
    output logic                                               o_cfg_ready,
    input  logic [alg_pkg::CFG_IDX_BITS-1:0]                   i_cfg_index,
    input  logic [(DIST_BITS > SAMPLE_BITS ? DIST_BITS : SAMPLE_BITS)-1:0] i_cfg_data,
    // Request channel.
    input  logic                                               i_in_valid,
    output logic                                               o_in_stall,
    input  logic [alg_pkg::CMD_BITS-1:0]                       i_cmd,
    input  logic [SAMPLE_BITS-1:0]                             i_frame_time_us,
    input  logic [DIST_BITS-1:0]                               i_distance_cm,
    input  logic [alg_pkg::LVL_BITS-1:0]                       i_new_level,
    // Result channel.
    output logic                                               o_out_valid,
    input  logic                                               i_out_stall,
    output logic [alg_pkg::LVL_BITS-1:0]                       o_object_level,
    output logic                                               o_simulate,
    output logic [alg_pkg::COLL_BITS-1:0]                      o_collision_mode,
    output logic                                               o_notify_hits,
    output logic [alg_pkg::LVL_BITS-1:0]                       o_global_level,
    output logic                                               o_level_changed,
    output logic [alg_pkg::OUT_SUM_BITS-1:0]                   o_window_sum
);
    import alg_pkg::*;

    localparam int SUM_BITS = SAMPLE_BITS + $clog2(WINDOW_LEN);
    // Room for six times the product of target and window, and five times the sum.
    localparam int CMP_BITS = SUM_BITS + 3;
    localparam int CNT_BITS = $clog2(OUT_DEPTH + 1);

    // Configuration registers.
    logic [DIST_BITS-1:0]   r_near;
    logic [DIST_BITS-1:0]   r_mid;
    logic [DIST_BITS-1:0]   r_far;
    logic [SAMPLE_BITS-1:0] r_target;
    logic                   r_adapt;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near   <= DIST_BITS'(RESET_NEAR);
            r_mid    <= DIST_BITS'(RESET_MID);
            r_far    <= DIST_BITS'(RESET_FAR);
            r_target <= SAMPLE_BITS'(RESET_TARGET);
            r_adapt  <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_NEAR:   r_near   <= i_cfg_data[DIST_BITS-1:0];
                REG_MID:    r_mid    <= i_cfg_data[DIST_BITS-1:0];
                REG_FAR:    r_far    <= i_cfg_data[DIST_BITS-1:0];
                REG_TARGET: r_target <= i_cfg_data[SAMPLE_BITS-1:0];
                REG_ADAPT:  r_adapt  <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Handshakes. The credit counter covers the first stage and the result queue,
    // so the second stage never has to wait for room.
    logic                in_take;
    logic                out_take;
    logic [CNT_BITS-1:0] r_cnt;

    assign o_in_stall = (r_cnt == CNT_BITS'(OUT_DEPTH));
    assign in_take    = i_in_valid && !o_in_stall;
    assign out_take   = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + CNT_BITS'(in_take) - CNT_BITS'(out_take);
        end
    end

    // Sample window: a shift line of cells with a running sum, advanced once per sample.
    logic [SUM_BITS-1:0] w_sum;

    alg_sample_chain #(
        .WINDOW_LEN (WINDOW_LEN),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (in_take && (i_cmd == CMD_SAMPLE)),
        .i_sample(i_frame_time_us),
        .o_sum   (w_sum)
    );

    // First stage: the distance is tested against every bound at every scaling, and
    // the stepping thresholds are formed, none of which depends on the global level.
    function automatic t_fit fit_bound(input logic [DIST_BITS-1:0] dist_cm,
                                       input logic [DIST_BITS-1:0] bound);
        logic [DIST_BITS+3:0] d10;
        logic [DIST_BITS+3:0] b7;
        logic [DIST_BITS:0]   d2;
        t_fit                 f;
        d10 = ((DIST_BITS+4)'(dist_cm) << 3) + ((DIST_BITS+4)'(dist_cm) << 1);
        b7  = ((DIST_BITS+4)'(bound) << 3) - (DIST_BITS+4)'(bound);
        d2  = (DIST_BITS+1)'(dist_cm) << 1;
        f.le_full = (dist_cm <= bound);
        f.le_70   = (d10 <= b7);
        f.le_50   = (d2 <= (DIST_BITS+1)'(bound));
        return f;
    endfunction

    logic [CMP_BITS-1:0] base;

    assign base = CMP_BITS'(r_target) * CMP_BITS'(WINDOW_LEN);

    logic                r_s1_valid;
    logic [CMD_BITS-1:0] r_s1_cmd;
    logic [LVL_BITS-1:0] r_s1_new_level;
    logic                r_s1_adapt;
    t_fit                r_s1_near;
    t_fit                r_s1_mid;
    t_fit                r_s1_far;
    logic [CMP_BITS-1:0] r_s1_hi;
    logic [CMP_BITS-1:0] r_s1_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= in_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_cmd       <= i_cmd;
            r_s1_new_level <= i_new_level;
            r_s1_adapt     <= r_adapt;
            r_s1_near      <= fit_bound(i_distance_cm, r_near);
            r_s1_mid       <= fit_bound(i_distance_cm, r_mid);
            r_s1_far       <= fit_bound(i_distance_cm, r_far);
            r_s1_hi        <= (base << 2) + (base << 1);
            r_s1_lo        <= base << 2;
        end
    end

    // Second stage: the global level steps, the query is classified at the level
    // left by the previous request, and the result goes into the queue. The running
    // sum seen here already includes this request's sample, if it carried one.
    logic [LVL_BITS-1:0] r_level;
    logic [LVL_BITS-1:0] n_level;
    logic [CMP_BITS-1:0] sum5;
    logic [LVL_BITS-1:0] obj;
    t_result             res;

    assign sum5 = (CMP_BITS'(w_sum) << 2) + CMP_BITS'(w_sum);

    function automatic logic pick(input t_fit f, input logic [LVL_BITS-1:0] lvl);
        logic hit;
        unique case (lvl)
            LVL_MEDIUM: hit = f.le_70;
            LVL_LOW:    hit = f.le_50;
            default:    hit = f.le_full;
        endcase
        return hit;
    endfunction

    always_comb begin
        n_level = r_level;
        obj     = LVL_HIGH;
        unique case (r_s1_cmd)
            CMD_SAMPLE: begin
                // Stepping moves only between high, medium and low.
                if (r_s1_adapt) begin
                    if (sum5 > r_s1_hi) begin
                        if (r_level == LVL_HIGH) begin
                            n_level = LVL_MEDIUM;
                        end else if (r_level == LVL_MEDIUM) begin
                            n_level = LVL_LOW;
                        end
                    end else if (sum5 < r_s1_lo) begin
                        if (r_level == LVL_LOW) begin
                            n_level = LVL_MEDIUM;
                        end else if (r_level == LVL_MEDIUM) begin
                            n_level = LVL_HIGH;
                        end
                    end
                end
            end
            CMD_QUERY: begin
                priority if (r_level == LVL_DISABLED) begin
                    obj = LVL_DISABLED;
                end else if (pick(r_s1_near, r_level)) begin
                    obj = LVL_HIGH;
                end else if (pick(r_s1_mid, r_level)) begin
                    obj = LVL_MEDIUM;
                end else if (pick(r_s1_far, r_level)) begin
                    obj = LVL_LOW;
                end else begin
                    obj = LVL_DISABLED;
                end
            end
            CMD_FORCE: begin
                n_level = r_s1_new_level;
            end
            default: begin
            end
        endcase
    end

    logic [SUM_BITS+OUT_SUM_BITS-1:0] sum_ext;

    assign sum_ext = {{OUT_SUM_BITS{1'b0}}, w_sum};

    always_comb begin
        res.object_level   = obj;
        res.simulate       = 1'b0;
        res.collision_mode = COLL_NONE;
        res.notify_hits    = 1'b0;
        if (r_s1_cmd == CMD_QUERY) begin
            res.simulate    = (obj == LVL_HIGH) || (obj == LVL_MEDIUM);
            res.notify_hits = (obj == LVL_HIGH);
            unique case (obj)
                LVL_HIGH, LVL_MEDIUM: res.collision_mode = COLL_PHYSICS;
                LVL_LOW:              res.collision_mode = COLL_QUERY;
                default:              res.collision_mode = COLL_NONE;
            endcase
        end
        res.global_level  = n_level;
        res.level_changed = (n_level != r_level);
        res.window_sum    = sum_ext[OUT_SUM_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= LVL_HIGH;
        end else if (r_s1_valid) begin
            r_level <= n_level;
        end
    end

    // Result queue: it decouples the receiver's stall from the request side.
    t_result q_data;

    alg_out_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (r_s1_valid),
        .i_data (res),
        .i_pop  (out_take),
        .o_valid(o_out_valid),
        .o_data (q_data)
    );

    assign o_object_level   = q_data.object_level;
    assign o_simulate       = q_data.simulate;
    assign o_collision_mode = q_data.collision_mode;
    assign o_notify_hits    = q_data.notify_hits;
    assign o_global_level   = q_data.global_level;
    assign o_level_changed  = q_data.level_changed;
    assign o_window_sum     = q_data.window_sum;

    `ALG_ASSERT_NOW(a_credit_bound, 1'b1, r_cnt <= CNT_BITS'(OUT_DEPTH), "credit count overflow")
    `ALG_ASSERT_NEXT(a_result_lands, r_s1_valid, o_out_valid, "result did not reach the queue")
    `ALG_ASSERT_NEXT(a_level_quiet, !r_s1_valid, $stable(r_level), "level moved without a request")
    `ALG_ASSERT_NOW(a_sim_flag, o_out_valid && o_simulate, o_object_level == LVL_HIGH || o_object_level == LVL_MEDIUM, "simulate set for a coarse level")
    `ALG_ASSERT_NOW(a_hits_flag, o_out_valid && o_notify_hits, o_object_level == LVL_HIGH, "hit events set below high detail")

endmodule

### tb/adaptive_lod_governor_tb.sv
`timescale 1ns / 1ps

module adaptive_lod_governor_tb;

    import alg_pkg::*;

    localparam int WINDOW      = 60;
    localparam int SAMPLE_W    = 16;
    localparam int DIST_W      = 20;
    localparam int CFG_W       = (DIST_W > SAMPLE_W) ? DIST_W : SAMPLE_W;
    localparam int DIST_MAX    = (1 << DIST_W) - 1;
    localparam int SAMPLE_MAX  = (1 << SAMPLE_W) - 1;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 72;
    // Quiet time allowed after the last result, before any register write and before the verdict.
    localparam int SETTLE_CYCLES    = 6;
    localparam int LONG_HOLD_CYCLES = 160;
    localparam int RUN_LIMIT_NS     = 2_000_000;

    // Command code 3 has no meaning to the block and must be ignored.
    localparam logic [CMD_BITS-1:0]     CMD_UNUSED      = 2'd3;
    // Register indexes 5 to 7 are not decoded.
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_FIRST = 3'd5;

    typedef struct packed {
        logic [CMD_BITS-1:0] cmd;
        logic [SAMPLE_W-1:0] frame_time;
        logic [DIST_W-1:0]   distance;
        logic [LVL_BITS-1:0] new_level;
    } t_request;

    // Block ports.
    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_IDX_BITS-1:0]   i_cfg_index;
    logic [CFG_W-1:0]          i_cfg_data;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic [CMD_BITS-1:0]       i_cmd = '0;
    logic [SAMPLE_W-1:0]       i_frame_time_us = '0;
    logic [DIST_W-1:0]         i_distance_cm = '0;
    logic [LVL_BITS-1:0]       i_new_level = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic [LVL_BITS-1:0]       o_object_level;
    logic                      o_simulate;
    logic [COLL_BITS-1:0]      o_collision_mode;
    logic                      o_notify_hits;
    logic [LVL_BITS-1:0]       o_global_level;
    logic                      o_level_changed;
    logic [OUT_SUM_BITS-1:0]   o_window_sum;

    // Requests waiting to be offered, and results predicted but not yet seen.
    t_request request_queue[$];
    t_result  predicted_results[$];

    // Private copy of the governor state and its registers.
    logic [SAMPLE_W-1:0] frame_ring [WINDOW];
    int unsigned         ring_slot;
    logic [63:0]         frame_sum;
    logic [LVL_BITS-1:0] global_lvl;
    logic [DIST_W-1:0]   near_bound;
    logic [DIST_W-1:0]   mid_bound;
    logic [DIST_W-1:0]   far_bound;
    logic [SAMPLE_W-1:0] target_us;
    logic                adaptive_on;

    int       mismatch_count  = 0;
    int       requests_taken  = 0;
    int       results_checked = 0;
    int       level_steps     = 0;
    int       config_writes   = 0;
    int       hold_requests   = 0;
    bit       request_taken   = 1'b0;
    t_request next_request;
    t_request taken_request;
    t_result  wanted;

    adaptive_lod_governor #(
        .WINDOW_LEN  (WINDOW),
        .SAMPLE_BITS (SAMPLE_W),
        .DIST_BITS   (DIST_W)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_cmd            (i_cmd),
        .i_frame_time_us  (i_frame_time_us),
        .i_distance_cm    (i_distance_cm),
        .i_new_level      (i_new_level),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_object_level   (o_object_level),
        .o_simulate       (o_simulate),
        .o_collision_mode (o_collision_mode),
        .o_notify_hits    (o_notify_hits),
        .o_global_level   (o_global_level),
        .o_level_changed  (o_level_changed),
        .o_window_sum     (o_window_sum)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // A generous ceiling on the whole run, far beyond the slowest legal schedule.
    initial begin
        #(RUN_LIMIT_NS);
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // True when a distance lies inside a bound once the bound has been scaled
    // for the given global level: full size at high, 7/10 at medium, 1/2 at low.
    function automatic bit inside_bound(logic [DIST_W-1:0] span_cm, logic [DIST_W-1:0] bound,
                                        logic [LVL_BITS-1:0] lvl);
        logic [63:0] d;
        logic [63:0] b;
        d = span_cm;
        b = bound;
        if (lvl == LVL_MEDIUM) return (d * 10) <= (b * 7);
        if (lvl == LVL_LOW) return (d * 2) <= b;
        return d <= b;
    endfunction

    function automatic logic [LVL_BITS-1:0] classify_distance(logic [DIST_W-1:0] span_cm);
        if (global_lvl == LVL_DISABLED) return LVL_DISABLED;
        if (inside_bound(span_cm, near_bound, global_lvl)) return LVL_HIGH;
        if (inside_bound(span_cm, mid_bound, global_lvl)) return LVL_MEDIUM;
        if (inside_bound(span_cm, far_bound, global_lvl)) return LVL_LOW;
        return LVL_DISABLED;
    endfunction

    // Applies one request to the private state and returns the result the block
    // must give for it.
    function automatic t_result govern_request(t_request rq);
        t_result             r;
        logic [LVL_BITS-1:0] prior;
        logic [63:0]         scaled;
        logic [63:0]         base;
        r = '0;
        prior = global_lvl;
        case (rq.cmd)
            CMD_SAMPLE: begin
                frame_sum = frame_sum - frame_ring[ring_slot] + rq.frame_time;
                frame_ring[ring_slot] = rq.frame_time;
                ring_slot = (ring_slot == WINDOW - 1) ? 0 : ring_slot + 1;
                if (adaptive_on) begin
                    // Exact forms of sum > 1.2 * target * window and
                    // sum < 0.8 * target * window.
                    scaled = frame_sum * 5;
                    base = 64'(target_us) * WINDOW;
                    if (scaled > base * 6) begin
                        if (global_lvl == LVL_HIGH) global_lvl = LVL_MEDIUM;
                        else if (global_lvl == LVL_MEDIUM) global_lvl = LVL_LOW;
                    end else if (scaled < base * 4) begin
                        if (global_lvl == LVL_LOW) global_lvl = LVL_MEDIUM;
                        else if (global_lvl == LVL_MEDIUM) global_lvl = LVL_HIGH;
                    end
                end
            end
            CMD_QUERY: begin
                r.object_level = classify_distance(rq.distance);
                r.simulate = (r.object_level == LVL_HIGH) || (r.object_level == LVL_MEDIUM);
                if (r.simulate) r.collision_mode = COLL_PHYSICS;
                else if (r.object_level == LVL_LOW) r.collision_mode = COLL_QUERY;
                else r.collision_mode = COLL_NONE;
                r.notify_hits = (r.object_level == LVL_HIGH);
            end
            CMD_FORCE: begin
                global_lvl = rq.new_level;
            end
            default: begin
            end
        endcase
        r.global_level = global_lvl;
        r.level_changed = (global_lvl != prior);
        r.window_sum = frame_sum[OUT_SUM_BITS-1:0];
        return r;
    endfunction

    task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // Everything is sampled on the rising edge. Register writes and taken
    // requests update the private state first, so that a result arriving on the
    // same edge would still find its expectation; then any delivered result is
    // checked against the oldest prediction.
    always @(posedge i_clk) begin
        request_taken = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_NEAR:   near_bound  = i_cfg_data[DIST_W-1:0];
                    REG_MID:    mid_bound   = i_cfg_data[DIST_W-1:0];
                    REG_FAR:    far_bound   = i_cfg_data[DIST_W-1:0];
                    REG_TARGET: target_us   = i_cfg_data[SAMPLE_W-1:0];
                    REG_ADAPT:  adaptive_on = i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                request_taken = 1'b1;
                taken_request = '{i_cmd, i_frame_time_us, i_distance_cm, i_new_level};
                predicted_results.push_back(govern_request(taken_request));
                requests_taken++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (predicted_results.size() == 0) begin
                    $display("%0t ns: result delivered with no request outstanding", $time);
                    mismatch_count++;
                end else begin
                    wanted = predicted_results.pop_front();
                    compare_field("object_level", wanted.object_level, o_object_level);
                    compare_field("simulate", wanted.simulate, o_simulate);
                    compare_field("collision_mode", wanted.collision_mode, o_collision_mode);
                    compare_field("notify_hits", wanted.notify_hits, o_notify_hits);
                    compare_field("global_level", wanted.global_level, o_global_level);
                    compare_field("level_changed", wanted.level_changed, o_level_changed);
                    compare_field("window_sum", wanted.window_sum, o_window_sum);
                    if (wanted.level_changed) level_steps++;
                    results_checked++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request driver: bursts of random length separated by random gaps.
    // A request that is being stalled keeps its payload untouched; a new one
    // is put up only once the previous request has been taken.
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || request_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (request_queue.size() > 0) begin
                next_request = request_queue.pop_front();
                i_cmd           <= next_request.cmd;
                i_frame_time_us <= next_request.frame_time;
                i_distance_cm   <= next_request.distance;
                i_new_level     <= next_request.new_level;
                i_in_valid      <= 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    // Occasional long bursts give stretches with no sender idling.
                    burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 120)
                                                             : $urandom_range(1, 30);
                    case ($urandom_range(0, 7))
                        0, 1, 2: gap_left = 0;
                        3, 4, 5: gap_left = $urandom_range(1, 3);
                        6:       gap_left = $urandom_range(4, 10);
                        default: gap_left = $urandom_range(15, 30);
                    endcase
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: segments of random length, each with its own stall
    // style. When asked, it holds off completely for a long stretch so that the
    // block's result store fills and its request channel stalls.
    // ------------------------------------------------------------------
    int hold_left    = 0;
    int holds_served = 0;
    int segment_left = 0;
    int stall_style  = 0;
    int stall_phase  = 0;

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (holds_served < hold_requests) begin
            holds_served++;
            hold_left = LONG_HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            if (segment_left == 0) begin
                segment_left = $urandom_range(10, 120);
                stall_style = $urandom_range(0, 3);
            end else begin
                segment_left--;
            end
            stall_phase = (stall_phase == 2) ? 0 : stall_phase + 1;
            case (stall_style)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                2:       i_out_stall <= ($urandom_range(0, 3) != 0);
                default: i_out_stall <= (stall_phase == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Queues one request; the fields its command does not use carry noise.
    task automatic add_request(logic [CMD_BITS-1:0] cmd, logic [DIST_W-1:0] arg);
        t_request rq;
        rq.cmd = cmd;
        rq.frame_time = (cmd == CMD_SAMPLE) ? arg[SAMPLE_W-1:0]
                                            : SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
        rq.distance = (cmd == CMD_QUERY) ? arg : DIST_W'($urandom_range(0, DIST_MAX));
        rq.new_level = (cmd == CMD_FORCE) ? arg[LVL_BITS-1:0] : LVL_BITS'($urandom_range(0, 3));
        request_queue.push_back(rq);
    endtask

    task automatic write_register(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        config_writes++;
    endtask

    // Waits until every queued request has been taken and answered, then lets the
    // settle time pass so the block is idle.
    task automatic wait_until_idle();
        while (request_queue.size() != 0 || i_in_valid || predicted_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Distances cluster around the scaled bounds, where the comparisons turn,
    // with a share drawn from the full field range.
    function automatic logic [DIST_W-1:0] random_distance();
        int b;
        int d;
        if ($urandom_range(0, 9) < 4) return DIST_W'($urandom_range(0, DIST_MAX));
        case ($urandom_range(0, 2))
            0:       b = near_bound;
            1:       b = mid_bound;
            default: b = far_bound;
        endcase
        case ($urandom_range(0, 2))
            0:       d = b;
            1:       d = b * 7 / 10;
            default: d = b / 2;
        endcase
        d = d + int'($urandom_range(0, 4)) - 2;
        if (d < 0) d = 0;
        if (d > DIST_MAX) d = DIST_MAX;
        return DIST_W'(d);
    endfunction

    // Frame times come in runs that lean slow, fast, near target or anywhere,
    // so the window sum crosses both thresholds and the level walks both ways.
    task automatic queue_random(int count);
        int lean;
        int run_left;
        int pick;
        int t;
        int v;
        lean = 0;
        run_left = 0;
        for (int k = 0; k < count; k++) begin
            if (run_left == 0) begin
                lean = $urandom_range(0, 3);
                run_left = $urandom_range(8, 24);
            end
            run_left--;
            pick = $urandom_range(0, 99);
            t = target_us;
            if (pick < 50) begin
                case (lean)
                    0:       v = t * int'($urandom_range(120, 200)) / 100;
                    1:       v = t * int'($urandom_range(0, 75)) / 100;
                    2:       v = t * int'($urandom_range(75, 125)) / 100;
                    default: v = $urandom_range(0, SAMPLE_MAX);
                endcase
                if (v > SAMPLE_MAX) v = SAMPLE_MAX;
                add_request(CMD_SAMPLE, DIST_W'(v));
            end else if (pick < 88) begin
                add_request(CMD_QUERY, random_distance());
            end else if (pick < 96) begin
                add_request(CMD_FORCE, DIST_W'($urandom_range(0, 3)));
            end else begin
                add_request(CMD_UNUSED, DIST_W'($urandom_range(0, DIST_MAX)));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        logic [DIST_W-1:0]   nb;
        logic [DIST_W-1:0]   mb;
        logic [DIST_W-1:0]   fb;
        logic [SAMPLE_W-1:0] tgt;
        logic                adp;

        // The private state starts where the block's reset leaves it.
        for (int k = 0; k < WINDOW; k++) frame_ring[k] = RESET_TARGET;
        ring_slot   = 0;
        frame_sum   = 64'(WINDOW) * RESET_TARGET;
        global_lvl  = LVL_HIGH;
        near_bound  = RESET_NEAR;
        mid_bound   = RESET_MID;
        far_bound   = RESET_FAR;
        target_us   = RESET_TARGET;
        adaptive_on = 1'b1;

        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests under the reset registers. Queries first walk the
        // unscaled bound edges and the far end of the distance range.
        add_request(CMD_QUERY, 0);
        add_request(CMD_QUERY, RESET_NEAR);
        add_request(CMD_QUERY, RESET_NEAR + 1);
        add_request(CMD_QUERY, RESET_MID + 1);
        add_request(CMD_QUERY, RESET_FAR);
        add_request(CMD_QUERY, RESET_FAR + 1);
        add_request(CMD_QUERY, DIST_MAX);
        // At medium the bounds shrink to seven tenths, at low to one half.
        add_request(CMD_FORCE, LVL_MEDIUM);
        add_request(CMD_QUERY, RESET_NEAR * 7 / 10);
        add_request(CMD_QUERY, RESET_NEAR * 7 / 10 + 1);
        add_request(CMD_FORCE, LVL_LOW);
        add_request(CMD_QUERY, RESET_NEAR / 2);
        add_request(CMD_QUERY, RESET_NEAR / 2 + 1);
        add_request(CMD_QUERY, RESET_FAR / 2);
        // A disabled global level answers every query with disabled, and
        // frame timing cannot move it out of that level.
        add_request(CMD_FORCE, LVL_DISABLED);
        add_request(CMD_QUERY, 0);
        add_request(CMD_SAMPLE, SAMPLE_MAX);
        add_request(CMD_SAMPLE, 0);
        // The unused command code is ignored, whatever its fields hold.
        add_request(CMD_UNUSED, DIST_MAX);
        // Long frames step the level down one place at a time until it sticks
        // at low.
        add_request(CMD_FORCE, LVL_HIGH);
        repeat (6) add_request(CMD_SAMPLE, SAMPLE_MAX);
        add_request(CMD_QUERY, RESET_NEAR / 2);
        wait_until_idle();

        for (int ph = 0; ph < PHASES; ph++) begin
            nb  = $urandom_range(0, DIST_MAX);
            mb  = nb + $urandom_range(0, DIST_MAX - nb);
            fb  = mb + $urandom_range(0, DIST_MAX - mb);
            tgt = $urandom_range(1, SAMPLE_MAX);
            adp = 1'b1;
            case (ph)
                0: begin
                    nb = RESET_NEAR; mb = RESET_MID; fb = RESET_FAR; tgt = RESET_TARGET;
                end
                1: begin
                    // Smallest bounds and target: only distance zero stays
                    // near, and almost any sum steps the level down.
                    nb = 0; mb = 0; fb = 0; tgt = 1;
                end
                2: begin
                    // Largest bounds and target: the level climbs back up.
                    nb = DIST_MAX; mb = DIST_MAX; fb = DIST_MAX; tgt = SAMPLE_MAX;
                end
                3: tgt = 0;  // A zero target never steps up; any nonzero sum steps down.
                4: begin
                    tgt = $urandom_range(8000, 40000);
                    adp = 1'b0;
                end
                5: begin
                    // Bounds out of order.
                    nb = $urandom_range(0, DIST_MAX);
                    mb = $urandom_range(0, DIST_MAX);
                    fb = $urandom_range(0, DIST_MAX);
                end
                6: begin
                    nb = $urandom_range(0, 2000);
                    mb = nb + $urandom_range(0, 3000);
                    fb = mb + $urandom_range(0, 5000);
                    tgt = $urandom_range(12000, 20000);
                end
                7: tgt = 10000;
                default: begin
                end
            endcase
            write_register(REG_NEAR, nb);
            write_register(REG_MID, mb);
            write_register(REG_FAR, fb);
            write_register(REG_TARGET, tgt);
            write_register(REG_ADAPT, adp);
            // Writes to undecoded indexes must leave every register alone.
            if (ph == 4) write_register(REG_SPARE_FIRST + $urandom_range(0, 2),
                                        $urandom_range(0, DIST_MAX));
            queue_random(PHASE_ITEMS / 2);
            // In one phase the receiver holds off for a long stretch while the
            // sender keeps offering requests.
            if (ph == 2) hold_requests++;
            // In another the sender pauses until every result has come back.
            if (ph == 0) wait_until_idle();
            queue_random(PHASE_ITEMS - PHASE_ITEMS / 2);
            wait_until_idle();
        end

        if (predicted_results.size() != 0) begin
            $display("%0t ns: %0d predicted results never delivered", $time,
                     predicted_results.size());
            mismatch_count++;
        end
        $display("Covered %0d requests and %0d checked results over %0d register writes,",
                 requests_taken, results_checked, config_writes);
        $display("with %0d global level changes, a long result hold-off and a sender pause.",
                 level_steps);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
